FILE: rtl/core/hds_pkg.sv
// ============================================================================
// hds_pkg
// Shared types and constants for the hemisphere direction sampler.
// ============================================================================
package hds_pkg;

  // Vector and fraction formats.
  localparam int VEC_W     = 16;
  localparam int FRAC_BITS = 14;
  localparam int RAND_BITS = 16;
  localparam int H_W       = FRAC_BITS + 1;

  // CORDIC datapath: Q30 values with headroom, angles in turns scaled by 2^32.
  localparam int CORDIC_FRAC = 30;
  localparam int CORDIC_W    = 34;
  localparam int ATAN_N      = 32;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // atan(2^-i) as a fraction of a turn, scaled by 2^32.
  localparam logic [31:0] ATAN_TURN [0:ATAN_N-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // Input item.
  typedef struct packed {
    logic signed [VEC_W-1:0] normal_x;
    logic signed [VEC_W-1:0] normal_y;
    logic signed [VEC_W-1:0] normal_z;
    logic [RAND_BITS-1:0]    rand_height;
    logic [RAND_BITS-1:0]    rand_azimuth;
  } hds_in_t;

  // Result item.
  typedef struct packed {
    logic signed [VEC_W-1:0] dir_x;
    logic signed [VEC_W-1:0] dir_y;
    logic signed [VEC_W-1:0] dir_z;
    logic                    degenerate;
  } hds_out_t;

  // Normal, height and tangent branch carried down the pipeline.
  typedef struct packed {
    logic signed [VEC_W-1:0] nx;
    logic signed [VEC_W-1:0] ny;
    logic signed [VEC_W-1:0] nz;
    logic [H_W-1:0]          h;
    logic                    sel_x;
  } hds_geom_t;

endpackage

FILE: rtl/core/hds_isqrt_pipe.sv
// ============================================================================
// hds_isqrt_pipe
// Pipelined integer square root, one result bit per register stage up to RW.
// ============================================================================
module hds_isqrt_pipe #(
  parameter int RW     = 16,
  parameter int STAGES = 16
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] rad_i,
  output logic [RW-1:0]   root_o
);

  logic [2*RW-1:0] rad_r  [0:STAGES];
  logic [RW+1:0]   rem_r  [0:STAGES];
  logic [RW-1:0]   root_r [0:STAGES];

  assign rad_r[0]  = rad_i;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;

  // Each stage brings down two radicand bits and decides one root bit.
  for (genvar s = 1; s <= STAGES; s++) begin : g_stage
    if (s <= RW) begin : g_step
      logic [RW+1:0] rem_sh;
      logic [RW+1:0] trial;
      logic          ge;

      assign rem_sh = {rem_r[s-1][RW-1:0], rad_r[s-1][2*RW-1 -: 2]};
      assign trial  = {root_r[s-1], 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[s]  <= {rad_r[s-1][2*RW-3:0], 2'b00};
          rem_r[s]  <= ge ? (rem_sh - trial) : rem_sh;
          root_r[s] <= {root_r[s-1][RW-2:0], ge};
        end
      end
    end else begin : g_pass
      // Padding stages keep the latency equal to the other front units.
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[s]  <= rad_r[s-1];
          rem_r[s]  <= rem_r[s-1];
          root_r[s] <= root_r[s-1];
        end
      end
    end
  end

  assign root_o = root_r[STAGES];

endmodule

FILE: rtl/core/hemisphere_direction_sampler_top.sv
// ============================================================================
// hemisphere_direction_sampler_top
// Uniform hemisphere direction sampler around a unit normal, fully pipelined.
// ============================================================================
// Usage:
//   The input channel (in_valid, in_stall, in_item) carries a Q1.14 normal and
//   two 0.16 uniform fractions. The output channel (out_valid, out_stall,
//   out_item) returns one Q1.14 direction per item, plus a degenerate flag
//   that is set, with a zero direction, when the tangent length is zero.
//   The front section is FRONT stages deep, where FRONT is the larger of 16
//   and CORDIC_STEPS. It runs the CORDIC rotations and both square roots one
//   step per stage side by side, and the tangent division takes one quotient
//   bit per stage after it. Throughput is one item per cycle while the output
//   is not stalled; every stage holds its own valid bit. When the receiver
//   stalls with a result waiting, the whole pipeline holds and in_stall is
//   raised in the same cycle; nothing is dropped or repeated.
//   Reset clears all valid bits; no item is in flight after reset.
// ============================================================================
module hemisphere_direction_sampler_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  hds_pkg::hds_in_t in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output hds_pkg::hds_out_t out_item
);

  import hds_pkg::*;

  localparam int FRONT     = (CORDIC_STEPS > 16) ? CORDIC_STEPS : 16;
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int N_PRE     = FRONT + 9 + DIV_STEPS;
  localparam int CS_SHIFT  = CORDIC_FRAC - FRAC_BITS;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int RAD_R_W   = 2 * H_W;
  localparam int RAD_L_W   = 2 * VEC_W;
  localparam int DIV_W     = VEC_W + FRAC_BITS;

  // Round a Q30 CORDIC value to Q1.14 and clamp to [-1, 1].
  function automatic logic signed [VEC_W-1:0] cordic_round(
    input logic signed [CORDIC_W-1:0] v
  );
    logic signed [CORDIC_W-1:0] t;
    t = (v + CORDIC_W'(1 << (CS_SHIFT - 1))) >>> CS_SHIFT;
    if (t > CORDIC_W'(ONE)) begin
      return VEC_W'(ONE);
    end else if (t < -CORDIC_W'(ONE)) begin
      return -VEC_W'(ONE);
    end
    return t[VEC_W-1:0];
  endfunction

  // Magnitude of a signed vector component.
  function automatic logic [VEC_W:0] mag(input logic signed [VEC_W-1:0] v);
    logic signed [VEC_W:0] e;
    e = (VEC_W+1)'(v);
    return e[VEC_W] ? (VEC_W+1)'(-e) : (VEC_W+1)'(e);
  endfunction

  // Global advance: the pipeline moves unless a waiting result is stalled.
  logic en;
  logic out_valid_r;
  hds_out_t out_item_r;
  logic vld_r [0:N_PRE-1];

  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_PRE; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < N_PRE; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_valid_r <= vld_r[N_PRE-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: height, tangent branch and input capture.
  // --------------------------------------------------------------------------
  logic [RAND_BITS+FRAC_BITS:0] hsum;
  logic [VEC_W:0]               ax_in;
  logic [VEC_W:0]               ay_in;
  logic                         sel_in;
  hds_geom_t                    s1_geom_r;
  logic signed [VEC_W-1:0]      s1_a_r;
  logic [RAND_BITS-1:0]         s1_az_r;

  assign hsum   = {1'b0, in_item.rand_height, FRAC_BITS'(0)}
                + (RAND_BITS+FRAC_BITS+1)'(1 << (RAND_BITS - 1));
  assign ax_in  = mag(in_item.normal_x);
  assign ay_in  = mag(in_item.normal_y);
  assign sel_in = (ax_in > ay_in);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_geom_r.nx    <= in_item.normal_x;
      s1_geom_r.ny    <= in_item.normal_y;
      s1_geom_r.nz    <= in_item.normal_z;
      s1_geom_r.h     <= hsum[RAND_BITS+FRAC_BITS -: H_W];
      s1_geom_r.sel_x <= sel_in;
      s1_a_r          <= sel_in ? in_item.normal_x : in_item.normal_y;
      s1_az_r         <= in_item.rand_azimuth;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: squares for both square roots.
  // --------------------------------------------------------------------------
  hds_geom_t               s2_geom_r;
  logic [RAND_BITS-1:0]    s2_az_r;
  logic [RAD_R_W-1:0]      s2_hh_r;
  logic signed [RAD_L_W-1:0] s2_asq_r;
  logic signed [RAD_L_W-1:0] s2_zsq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_geom_r <= s1_geom_r;
      s2_az_r   <= s1_az_r;
      s2_hh_r   <= s1_geom_r.h * s1_geom_r.h;
      s2_asq_r  <= s1_a_r * s1_a_r;
      s2_zsq_r  <= s1_geom_r.nz * s1_geom_r.nz;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: square-root radicands and CORDIC angle.
  // --------------------------------------------------------------------------
  hds_geom_t            s3_geom_r;
  logic [RAND_BITS-1:0] s3_az_r;
  logic [RAD_R_W-1:0]   s3_radr_r;
  logic [RAD_L_W-1:0]   s3_radl_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_geom_r <= s2_geom_r;
      s3_az_r   <= s2_az_r;
      s3_radr_r <= RAD_R_W'(1 << (2 * FRAC_BITS)) - s2_hh_r;
      s3_radl_r <= RAD_L_W'(s2_asq_r) + RAD_L_W'(s2_zsq_r);
    end
  end

  // --------------------------------------------------------------------------
  // Front section: CORDIC rotations beside the two square roots.
  // --------------------------------------------------------------------------
  logic signed [CORDIC_W-1:0] cx_r [0:FRONT];
  logic signed [CORDIC_W-1:0] cy_r [0:FRONT];
  logic signed [CORDIC_W-1:0] cz_r [0:FRONT];
  logic [1:0]                 quad_r [0:FRONT];
  hds_geom_t                  fgeom_r [0:FRONT];
  logic [H_W-1:0]             r_root;
  logic [VEC_W-1:0]           len_root;

  assign cx_r[0]    = CORDIC_GAIN;
  assign cy_r[0]    = '0;
  assign cz_r[0]    = CORDIC_W'({s3_az_r[RAND_BITS-3:0], (32 - RAND_BITS)'(0)});
  assign quad_r[0]  = s3_az_r[RAND_BITS-1 -: 2];
  assign fgeom_r[0] = s3_geom_r;

  for (genvar s = 1; s <= FRONT; s++) begin : g_front
    if (s <= CORDIC_STEPS) begin : g_rot
      localparam logic signed [CORDIC_W-1:0] AT =
        $signed({{(CORDIC_W-32){1'b0}}, ATAN_TURN[s-1]});
      always_ff @(posedge clk) begin
        if (en) begin
          if (cz_r[s-1] >= 0) begin
            cx_r[s] <= cx_r[s-1] - (cy_r[s-1] >>> (s - 1));
            cy_r[s] <= cy_r[s-1] + (cx_r[s-1] >>> (s - 1));
            cz_r[s] <= cz_r[s-1] - AT;
          end else begin
            cx_r[s] <= cx_r[s-1] + (cy_r[s-1] >>> (s - 1));
            cy_r[s] <= cy_r[s-1] - (cx_r[s-1] >>> (s - 1));
            cz_r[s] <= cz_r[s-1] + AT;
          end
          quad_r[s]  <= quad_r[s-1];
          fgeom_r[s] <= fgeom_r[s-1];
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en) begin
          cx_r[s]    <= cx_r[s-1];
          cy_r[s]    <= cy_r[s-1];
          cz_r[s]    <= cz_r[s-1];
          quad_r[s]  <= quad_r[s-1];
          fgeom_r[s] <= fgeom_r[s-1];
        end
      end
    end
  end

  hds_isqrt_pipe #(.RW(H_W), .STAGES(FRONT)) u_sqrt_radius (
    .clk    (clk),
    .en     (en),
    .rad_i  (s3_radr_r),
    .root_o (r_root)
  );

  hds_isqrt_pipe #(.RW(VEC_W), .STAGES(FRONT)) u_sqrt_len (
    .clk    (clk),
    .en     (en),
    .rad_i  (s3_radl_r),
    .root_o (len_root)
  );

  // --------------------------------------------------------------------------
  // P1: quadrant map, rounding, division setup.
  // --------------------------------------------------------------------------
  logic signed [CORDIC_W-1:0] qc;
  logic signed [CORDIC_W-1:0] qs;
  hds_geom_t                  fg;
  logic signed [VEC_W-1:0]    fa;
  logic [VEC_W:0]             mag_z;
  logic [VEC_W:0]             mag_a;

  assign fg    = fgeom_r[FRONT];
  assign fa    = fg.sel_x ? fg.nx : fg.ny;
  assign mag_z = mag(fg.nz);
  assign mag_a = mag(fa);

  always_comb begin
    case (quad_r[FRONT])
      2'd0: begin
        qc = cx_r[FRONT];
        qs = cy_r[FRONT];
      end
      2'd1: begin
        qc = -cy_r[FRONT];
        qs = cx_r[FRONT];
      end
      2'd2: begin
        qc = -cx_r[FRONT];
        qs = -cy_r[FRONT];
      end
      default: begin
        qc = cy_r[FRONT];
        qs = -cx_r[FRONT];
      end
    endcase
  end

  hds_geom_t               p1_geom_r;
  logic signed [VEC_W-1:0] p1_cs_r;
  logic signed [VEC_W-1:0] p1_sn_r;
  logic [H_W-1:0]          p1_r_r;
  logic [VEC_W-1:0]        p1_len_r;
  logic [DIV_W-1:0]        p1_d1_r;
  logic [DIV_W-1:0]        p1_d2_r;
  logic                    p1_neg1_r;
  logic                    p1_neg2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_geom_r <= fg;
      p1_cs_r   <= cordic_round(qc);
      p1_sn_r   <= cordic_round(qs);
      p1_r_r    <= r_root;
      p1_len_r  <= len_root;
      p1_d1_r   <= DIV_W'({mag_z, FRAC_BITS'(0)}) + DIV_W'(len_root >> 1);
      p1_d2_r   <= DIV_W'({mag_a, FRAC_BITS'(0)}) + DIV_W'(len_root >> 1);
      p1_neg1_r <= fg.nz[VEC_W-1];
      p1_neg2_r <= (fa > 0);
    end
  end

  // --------------------------------------------------------------------------
  // P2: local-frame products and quotient overflow check.
  // --------------------------------------------------------------------------
  logic signed [2*VEC_W-1:0] p2_lxp_r;
  logic signed [2*VEC_W-1:0] p2_lyp_r;
  logic [DIV_W:0]            len_top;

  assign len_top = {p1_len_r, (DIV_STEPS)'(0)};

  // Divider arrays: index 0 is the P2 register, then one quotient bit a stage.
  hds_geom_t               dgeom_r [0:DIV_STEPS];
  logic [VEC_W-1:0]        dlen_r  [0:DIV_STEPS];
  logic [DIV_W-1:0]        drem1_r [0:DIV_STEPS];
  logic [DIV_W-1:0]        drem2_r [0:DIV_STEPS];
  logic [DIV_STEPS-1:0]    dq1_r   [0:DIV_STEPS];
  logic [DIV_STEPS-1:0]    dq2_r   [0:DIV_STEPS];
  logic                    dov1_r  [0:DIV_STEPS];
  logic                    dov2_r  [0:DIV_STEPS];
  logic                    dneg1_r [0:DIV_STEPS];
  logic                    dneg2_r [0:DIV_STEPS];
  logic signed [VEC_W-1:0] dlx_r   [1:DIV_STEPS];
  logic signed [VEC_W-1:0] dly_r   [1:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      p2_lxp_r   <= $signed({1'b0, p1_r_r}) * p1_cs_r;
      p2_lyp_r   <= $signed({1'b0, p1_r_r}) * p1_sn_r;
      dgeom_r[0] <= p1_geom_r;
      dlen_r[0]  <= p1_len_r;
      drem1_r[0] <= p1_d1_r;
      drem2_r[0] <= p1_d2_r;
      dq1_r[0]   <= '0;
      dq2_r[0]   <= '0;
      dov1_r[0]  <= ({1'b0, p1_d1_r} >= len_top);
      dov2_r[0]  <= ({1'b0, p1_d2_r} >= len_top);
      dneg1_r[0] <= p1_neg1_r;
      dneg2_r[0] <= p1_neg2_r;
    end
  end

  // Restoring division, quotient bits from the top down.
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [DIV_W:0] trial;
    logic           ge1;
    logic           ge2;

    assign trial = (DIV_W+1)'(dlen_r[k-1]) << (DIV_STEPS - k);
    assign ge1   = ({1'b0, drem1_r[k-1]} >= trial);
    assign ge2   = ({1'b0, drem2_r[k-1]} >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        dgeom_r[k] <= dgeom_r[k-1];
        dlen_r[k]  <= dlen_r[k-1];
        drem1_r[k] <= ge1 ? DIV_W'({1'b0, drem1_r[k-1]} - trial) : drem1_r[k-1];
        drem2_r[k] <= ge2 ? DIV_W'({1'b0, drem2_r[k-1]} - trial) : drem2_r[k-1];
        dq1_r[k]   <= {dq1_r[k-1][DIV_STEPS-2:0], ge1};
        dq2_r[k]   <= {dq2_r[k-1][DIV_STEPS-2:0], ge2};
        dov1_r[k]  <= dov1_r[k-1];
        dov2_r[k]  <= dov2_r[k-1];
        dneg1_r[k] <= dneg1_r[k-1];
        dneg2_r[k] <= dneg2_r[k-1];
      end
    end

    if (k == 1) begin : g_lround
      // Round the local-frame products while the divider runs.
      logic signed [2*VEC_W-1:0] lxr;
      logic signed [2*VEC_W-1:0] lyr;
      assign lxr = (p2_lxp_r + (2*VEC_W)'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
      assign lyr = (p2_lyp_r + (2*VEC_W)'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
      always_ff @(posedge clk) begin
        if (en) begin
          dlx_r[k] <= lxr[VEC_W-1:0];
          dly_r[k] <= lyr[VEC_W-1:0];
        end
      end
    end else begin : g_lcarry
      always_ff @(posedge clk) begin
        if (en) begin
          dlx_r[k] <= dlx_r[k-1];
          dly_r[k] <= dly_r[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // T: clamp and sign the tangent components.
  // --------------------------------------------------------------------------
  logic [VEC_W-1:0]        tm1;
  logic [VEC_W-1:0]        tm2;
  logic signed [VEC_W-1:0] tv1;
  logic signed [VEC_W-1:0] tv2;

  assign tm1 = (dov1_r[DIV_STEPS] || (dq1_r[DIV_STEPS] > DIV_STEPS'(ONE)))
             ? VEC_W'(ONE) : VEC_W'(dq1_r[DIV_STEPS]);
  assign tm2 = (dov2_r[DIV_STEPS] || (dq2_r[DIV_STEPS] > DIV_STEPS'(ONE)))
             ? VEC_W'(ONE) : VEC_W'(dq2_r[DIV_STEPS]);
  assign tv1 = dneg1_r[DIV_STEPS] ? -$signed(tm1) : $signed(tm1);
  assign tv2 = dneg2_r[DIV_STEPS] ? -$signed(tm2) : $signed(tm2);

  hds_geom_t               t_geom_r;
  logic                    t_deg_r;
  logic signed [VEC_W-1:0] t_lx_r;
  logic signed [VEC_W-1:0] t_ly_r;
  logic signed [VEC_W-1:0] t_t0_r;
  logic signed [VEC_W-1:0] t_t1_r;
  logic signed [VEC_W-1:0] t_t2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t_geom_r <= dgeom_r[DIV_STEPS];
      t_deg_r  <= (dlen_r[DIV_STEPS] == '0);
      t_lx_r   <= dlx_r[DIV_STEPS];
      t_ly_r   <= dly_r[DIV_STEPS];
      t_t0_r   <= dgeom_r[DIV_STEPS].sel_x ? tv1 : '0;
      t_t1_r   <= dgeom_r[DIV_STEPS].sel_x ? '0 : tv1;
      t_t2_r   <= tv2;
    end
  end

  // --------------------------------------------------------------------------
  // B1: cross-product terms.
  // --------------------------------------------------------------------------
  hds_geom_t                 b1_geom_r;
  logic                      b1_deg_r;
  logic signed [VEC_W-1:0]   b1_lx_r;
  logic signed [VEC_W-1:0]   b1_ly_r;
  logic signed [VEC_W-1:0]   b1_t_r [0:2];
  logic signed [2*VEC_W-1:0] b1_p_r [0:5];

  always_ff @(posedge clk) begin
    if (en) begin
      b1_geom_r <= t_geom_r;
      b1_deg_r  <= t_deg_r;
      b1_lx_r   <= t_lx_r;
      b1_ly_r   <= t_ly_r;
      b1_t_r[0] <= t_t0_r;
      b1_t_r[1] <= t_t1_r;
      b1_t_r[2] <= t_t2_r;
      b1_p_r[0] <= t_geom_r.ny * t_t2_r;
      b1_p_r[1] <= t_geom_r.nz * t_t1_r;
      b1_p_r[2] <= t_geom_r.nz * t_t0_r;
      b1_p_r[3] <= t_geom_r.nx * t_t2_r;
      b1_p_r[4] <= t_geom_r.nx * t_t1_r;
      b1_p_r[5] <= t_geom_r.ny * t_t0_r;
    end
  end

  // --------------------------------------------------------------------------
  // B2: bitangent components, rounded back to Q1.14.
  // --------------------------------------------------------------------------
  localparam int BD_W = 2 * VEC_W + 1;
  localparam int B_W  = BD_W - FRAC_BITS;

  logic signed [BD_W-1:0] bd [0:2];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      bd[c] = (BD_W'(b1_p_r[2*c]) - BD_W'(b1_p_r[2*c+1])
              + BD_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    end
  end

  hds_geom_t               b2_geom_r;
  logic                    b2_deg_r;
  logic signed [VEC_W-1:0] b2_lx_r;
  logic signed [VEC_W-1:0] b2_ly_r;
  logic signed [VEC_W-1:0] b2_t_r [0:2];
  logic signed [B_W-1:0]   b2_b_r [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      b2_geom_r <= b1_geom_r;
      b2_deg_r  <= b1_deg_r;
      b2_lx_r   <= b1_lx_r;
      b2_ly_r   <= b1_ly_r;
      for (int c = 0; c < 3; c++) begin
        b2_t_r[c] <= b1_t_r[c];
        b2_b_r[c] <= bd[c][B_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // C1: the three weighted terms of each direction component.
  // --------------------------------------------------------------------------
  localparam int PB_W = VEC_W + B_W;
  localparam int SUM_W = PB_W + 2;

  logic signed [VEC_W-1:0] nvec [0:2];

  assign nvec[0] = b2_geom_r.nx;
  assign nvec[1] = b2_geom_r.ny;
  assign nvec[2] = b2_geom_r.nz;

  logic                      c1_deg_r;
  logic signed [2*VEC_W-1:0] c1_pt_r [0:2];
  logic signed [PB_W-1:0]    c1_pb_r [0:2];
  logic signed [2*VEC_W-1:0] c1_pn_r [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      c1_deg_r <= b2_deg_r;
      for (int c = 0; c < 3; c++) begin
        c1_pt_r[c] <= b2_lx_r * b2_t_r[c];
        c1_pb_r[c] <= b2_ly_r * b2_b_r[c];
        c1_pn_r[c] <= $signed({1'b0, b2_geom_r.h}) * nvec[c];
      end
    end
  end

  // --------------------------------------------------------------------------
  // C2: sum, round, saturate, zero degenerate items and register the result.
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] dsum [0:2];
  logic signed [VEC_W-1:0] dsat [0:2];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dsum[c] = (SUM_W'(c1_pt_r[c]) + SUM_W'(c1_pb_r[c]) + SUM_W'(c1_pn_r[c])
                + SUM_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (c1_deg_r) begin
        dsat[c] = '0;
      end else if (dsum[c] > SUM_W'(ONE)) begin
        dsat[c] = VEC_W'(ONE);
      end else if (dsum[c] < -SUM_W'(ONE)) begin
        dsat[c] = -VEC_W'(ONE);
      end else begin
        dsat[c] = dsum[c][VEC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r.dir_x      <= dsat[0];
      out_item_r.dir_y      <= dsat[1];
      out_item_r.dir_z      <= dsat[2];
      out_item_r.degenerate <= c1_deg_r;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.degenerate |->
      (out_item_r.dir_x == 0) && (out_item_r.dir_y == 0) && (out_item_r.dir_z == 0))
    else $error("degenerate item with a nonzero direction");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (out_item_r.dir_x <= VEC_W'(ONE)) && (out_item_r.dir_x >= -VEC_W'(ONE)) &&
      (out_item_r.dir_y <= VEC_W'(ONE)) && (out_item_r.dir_y >= -VEC_W'(ONE)) &&
      (out_item_r.dir_z <= VEC_W'(ONE)) && (out_item_r.dir_z >= -VEC_W'(ONE)))
    else $error("direction component outside [-1, 1]");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted item did not enter the first stage");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(vld_r[N_PRE-1]))
    else $error("pipeline moved while the result was stalled");

endmodule
